[rtl/keyed_expiring_slot_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed expiring slot table
// Implication and next-cycle implication checks on a clock with async reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_EXPIRING_SLOT_TABLE_CORE_ASSERT_SVH
`define KEYED_EXPIRING_SLOT_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define KEST_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define KEST_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define KEST_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg)
`define KEST_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg)
`endif

`endif

[rtl/kest_pkg.sv]
// ----------------------------------------------------------------------------
// kest_pkg
// Shared types and constants of the keyed expiring slot table.
// ----------------------------------------------------------------------------
package kest_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;

    // floor(x / 1000) == (x * DECAY_RECIP) >> DECAY_SHIFT for x < 2^26
    localparam int          DECAY_SHIFT = 36;
    localparam logic [26:0] DECAY_RECIP = 27'd68719477;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_LIST  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // contents of one slot
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] expiry;
        logic [15:0] radius;
        logic [15:0] decay;
    } slot_rec_t;

    // controls from the sequencer to the ring and the decay head
    typedef struct packed {
        logic        shift_en;
        logic        tick_en;
        logic        wr_en;
        logic [31:0] now_ms;
        logic [9:0]  frame_ms;
        slot_rec_t   wr_rec;
    } ring_ctl_t;

endpackage

[rtl/kest_cell.sv]
// ----------------------------------------------------------------------------
// kest_cell
// One slot of the ring: holds a slot record, passes it on when the ring
// shifts, and takes a new record on a select write.
// ----------------------------------------------------------------------------
module kest_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic                wr_en,
    input  kest_pkg::slot_rec_t rec_in,
    input  kest_pkg::slot_rec_t wr_rec,
    output kest_pkg::slot_rec_t rec_out
);
    import kest_pkg::*;

    slot_rec_t rec_reg;
    slot_rec_t rec_next;

    // take the neighbor's record on a shift, the new record on a write
    always_comb
    begin
        rec_next = rec_reg;
        if (wr_en)
        begin
            rec_next = wr_rec;
        end
        else if (shift_en)
        begin
            rec_next = rec_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

[rtl/kest_head.sv]
// ----------------------------------------------------------------------------
// kest_head
// Two ring stages that apply the tick update to each record passing by:
// expire, or shrink by floor(frame_ms * decay / 1000) saturating at zero.
// ----------------------------------------------------------------------------
module kest_head
(
    input  logic                clk,
    input  logic                rst_n,
    input  kest_pkg::ring_ctl_t ctl,
    input  kest_pkg::slot_rec_t rec_in,
    output kest_pkg::slot_rec_t rec_out
);
    import kest_pkg::*;

    slot_rec_t   rec1_reg;
    logic        exp1_reg;
    logic [25:0] prod1_reg;
    slot_rec_t   rec2_reg;
    logic        exp2_reg;
    logic [16:0] quo2_reg;

    logic [52:0] scaled;

    // scale by the reciprocal of 1000
    assign scaled = 53'(prod1_reg) * 53'(DECAY_RECIP);

    // advance both stages with the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec1_reg  <= '0;
            exp1_reg  <= 1'b0;
            prod1_reg <= '0;
            rec2_reg  <= '0;
            exp2_reg  <= 1'b0;
            quo2_reg  <= '0;
        end
        else if (ctl.shift_en)
        begin
            rec1_reg  <= rec_in;
            exp1_reg  <= (rec_in.expiry < ctl.now_ms);
            prod1_reg <= 26'(ctl.frame_ms) * 26'(rec_in.decay);
            rec2_reg  <= rec1_reg;
            exp2_reg  <= exp1_reg;
            quo2_reg  <= scaled[DECAY_SHIFT +: 17];
        end
    end

    // update the radius of a live slot on a tick
    always_comb
    begin
        rec_out = rec2_reg;
        if (ctl.tick_en && (rec2_reg.radius != 16'd0))
        begin
            if (exp2_reg || (quo2_reg >= {1'b0, rec2_reg.radius}))
            begin
                rec_out.radius = 16'd0;
            end
            else
            begin
                rec_out.radius = rec2_reg.radius - quo2_reg[15:0];
            end
        end
    end

endmodule

[rtl/kest_ctrl.sv]
// ----------------------------------------------------------------------------
// kest_ctrl
// Sequencer: takes an item, walks the ring once, searches for the slot to
// allocate, collects list results, and holds the output register.
// ----------------------------------------------------------------------------
`include "keyed_expiring_slot_table_core_assert.svh"

module kest_ctrl
#(
    parameter int SLOTS = kest_pkg::SLOTS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kest_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [kest_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [kest_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [0:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  kest_pkg::slot_rec_t                  head_rec,
    output kest_pkg::ring_ctl_t                  ctl,
    output logic [$clog2(SLOTS)-1:0]             wr_idx
);
    import kest_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = $clog2(SLOTS + 2);
    localparam logic [SW-1:0]    LAST_STEP = SW'(SLOTS + 1);
    localparam logic [SW-1:0]    SLOT_END  = SW'(SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [SW-1:0]          step_reg, step_next;
    kind_t                  kind_reg, kind_next;
    logic [15:0]            key_reg, key_next;
    logic [31:0]            now_reg, now_next;
    logic [31:0]            die_reg, die_next;
    logic [15:0]            rad_reg, rad_next;
    logic [15:0]            dec_reg, dec_next;
    logic [9:0]             frame_reg, frame_next;
    logic                   kfound_reg, kfound_next;
    logic [IW-1:0]          kidx_reg, kidx_next;
    logic                   efound_reg, efound_next;
    logic [IW-1:0]          eidx_reg, eidx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [4:0]             pend_slot_reg, pend_slot_next;
    logic [15:0]            pend_key_reg, pend_key_next;
    logic [15:0]            pend_rad_reg, pend_rad_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;
    logic                   out_last_reg, out_last_next;

    logic          out_free;
    logic          in_range;
    logic          live;
    logic          stall;
    logic          shift_en;
    logic          wr_en;
    logic [IW-1:0] pick;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_range = (step_reg < SLOT_END);
    assign live     = (state_reg == ST_WALK) && (kind_reg == KIND_LIST) && in_range
                      && (head_rec.radius != 16'd0) && (cnt_reg < CNT_MAX);
    assign stall    = live && pend_valid_reg && !out_free;
    assign pick     = kfound_reg ? kidx_reg : (efound_reg ? eidx_reg : '0);

    // sequence one item through the ring walk
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        die_next        = die_reg;
        rad_next        = rad_reg;
        dec_next        = dec_reg;
        frame_next      = frame_reg;
        kfound_next     = kfound_reg;
        kidx_next       = kidx_reg;
        efound_next     = efound_reg;
        eidx_next       = eidx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_key_next   = pend_key_reg;
        pend_rad_next   = pend_rad_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;
        shift_en        = 1'b0;
        wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next       = kind_t'(s_axis_tuser);
                    key_next        = s_axis_tdata[15:0];
                    now_next        = s_axis_tdata[47:16];
                    die_next        = s_axis_tdata[79:48];
                    rad_next        = s_axis_tdata[95:80];
                    dec_next        = s_axis_tdata[111:96];
                    frame_next      = s_axis_tdata[121:112];
                    step_next       = '0;
                    kfound_next     = 1'b0;
                    efound_next     = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    if (kind_t'(s_axis_tuser) != KIND_NONE)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                shift_en = !stall;
                if (shift_en)
                begin
                    step_next = step_reg + 1'b1;
                    // search for a key match, then for an expired slot
                    if ((kind_reg == KIND_ALLOC) && in_range)
                    begin
                        if ((key_reg != 16'd0) && !kfound_reg && (head_rec.key == key_reg))
                        begin
                            kfound_next = 1'b1;
                            kidx_next   = step_reg[IW-1:0];
                        end
                        if (!efound_reg && (head_rec.expiry < now_reg))
                        begin
                            efound_next = 1'b1;
                            eidx_next   = step_reg[IW-1:0];
                        end
                    end
                    // hold one live slot back so the final one can carry last
                    if (live)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {3'b000, pend_rad_reg, pend_key_reg, pend_slot_reg};
                            out_user_next  = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 5'(step_reg);
                        pend_key_next   = head_rec.key;
                        pend_rad_next   = head_rec.radius;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_user_next  = 1'b0;
                    out_data_next  = '0;
                    case (kind_reg)
                        KIND_ALLOC:
                        begin
                            wr_en         = 1'b1;
                            out_user_next = 1'b1;
                            out_data_next = {3'b000, rad_reg, key_reg, 5'(pick)};
                        end
                        KIND_LIST:
                        begin
                            if (pend_valid_reg)
                            begin
                                out_user_next = 1'b1;
                                out_data_next = {3'b000, pend_rad_reg, pend_key_reg,
                                                 pend_slot_reg};
                            end
                        end
                        default:
                        begin
                            out_data_next = '0;
                        end
                    endcase
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            kfound_reg     <= 1'b0;
            efound_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            kfound_reg     <= kfound_next;
            efound_reg     <= efound_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        now_reg       <= now_next;
        die_reg       <= die_next;
        rad_reg       <= rad_next;
        dec_reg       <= dec_next;
        frame_reg     <= frame_next;
        kidx_reg      <= kidx_next;
        eidx_reg      <= eidx_next;
        pend_slot_reg <= pend_slot_next;
        pend_key_reg  <= pend_key_next;
        pend_rad_reg  <= pend_rad_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        out_last_reg  <= out_last_next;
    end

    // drive ports and ring controls
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser    = out_user_reg;
    assign m_axis_tlast    = out_last_reg;
    assign wr_idx          = pick;
    assign ctl.shift_en    = shift_en;
    assign ctl.tick_en     = (kind_reg == KIND_TICK);
    assign ctl.wr_en       = wr_en;
    assign ctl.now_ms      = now_reg;
    assign ctl.frame_ms    = frame_reg;
    assign ctl.wr_rec      = '{key: key_reg, expiry: die_reg, radius: rad_reg, decay: dec_reg};

    `KEST_ASSERT_IMPL(a_stall_only_list, clk, rst_n, (state_reg == ST_WALK) && !shift_en, (kind_reg == KIND_LIST) && pend_valid_reg && out_valid_reg, "ring stalled outside a list walk")
    `KEST_ASSERT_NEXT(a_finish_emits, clk, rst_n, (state_reg == ST_FINISH) && out_free, (state_reg == ST_IDLE) && out_valid_reg && out_last_reg, "finish did not emit a final result")
    `KEST_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_MAX, "list result count out of range")
    `KEST_ASSERT_IMPL(a_step_bound, clk, rst_n, state_reg == ST_WALK, step_reg <= LAST_STEP, "walk step out of range")
    `KEST_ASSERT_IMPL(a_write_finish, clk, rst_n, wr_en, (state_reg == ST_FINISH) && (kind_reg == KIND_ALLOC), "slot write outside allocate finish")

endmodule

[rtl/keyed_expiring_slot_table_core.sv]
// ----------------------------------------------------------------------------
// Results: the final result leaves after the ring walk, earlier list results
//   go out during the walk; kind 3 is accepted with no walk and no result.
// A new item is taken only once the last is done, after one full rotation
//   of the cell ring through the two-stage decay head.
// A list walk and every final result wait while the sink holds the output.
// Reset: asynchronous, clears every slot and all control at once.
// ----------------------------------------------------------------------------
// keyed_expiring_slot_table_core
// Ring of slot cells that rotates once per allocate, tick or list item.
// ----------------------------------------------------------------------------
module keyed_expiring_slot_table_core
#(
    parameter int SLOTS = kest_pkg::SLOTS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input transfer
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[15:0], now_ms[47:16], die_ms[79:48], start_radius[95:80],
    // decay_rate[111:96], frame_ms[121:112], zero[127:122]
    input  logic [kest_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [kest_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // output transfer
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot[4:0], slot_key[20:5], radius_out[36:21], zero[39:37]
    output logic [kest_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // entry_valid[0]
    output logic [0:0]                       m_axis_tuser,
    // last
    output logic                             m_axis_tlast
);
    import kest_pkg::*;

    localparam int IW = $clog2(SLOTS);

    slot_rec_t     cell_q [SLOTS];
    slot_rec_t     head_out;
    ring_ctl_t     ctl;
    logic [IW-1:0] wr_idx;

    // sequencer
    kest_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .head_rec      (cell_q[0]),
        .ctl           (ctl),
        .wr_idx        (wr_idx)
    );

    // decay head closes the ring
    kest_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rec_in  (cell_q[0]),
        .rec_out (head_out)
    );

    // row of slot cells, each handing its record toward cell 0
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        slot_rec_t nbr;
        logic      sel;

        if (i == SLOTS - 1)
        begin : g_tail
            assign nbr = head_out;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end

        assign sel = ctl.wr_en && (wr_idx == IW'(i));

        kest_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ctl.shift_en),
            .wr_en    (sel),
            .rec_in   (nbr),
            .wr_rec   (ctl.wr_rec),
            .rec_out  (cell_q[i])
        );
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Keyed expiring slot table - stream-level testbench
// Drives allocate, tick, list and unused-kind items into the core through
// its input stream and checks every output transfer against a shadow copy
// of the slot table, field by field and in order. Both stream sides idle
// and stall at random in phases, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module testbench;

    import kest_pkg::*;

    localparam int SLOTS          = kest_pkg::SLOTS_DEFAULT;
    localparam int RAND_TARGET    = 380;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 40;

    // stream idling phases
    localparam logic [1:0] IDLE_NONE = 2'd0;
    localparam logic [1:0] IDLE_SRC  = 2'd1;
    localparam logic [1:0] IDLE_SINK = 2'd2;
    localparam logic [1:0] IDLE_BOTH = 2'd3;

    typedef struct {
        kind_t       kind;
        logic [15:0] key;
        logic [31:0] now_ms;
        logic [31:0] die_ms;
        logic [15:0] start_radius;
        logic [15:0] decay_rate;
        logic [9:0]  frame_ms;
    } slot_req_t;

    typedef struct {
        logic [4:0]  slot;
        logic [15:0] slot_key;
        logic [15:0] radius_out;
        logic        entry_valid;
        logic        last;
    } slot_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;

    // shadow slot table
    logic [15:0] tbl_key    [SLOTS] = '{default: '0};
    logic [31:0] tbl_expiry [SLOTS] = '{default: '0};
    logic [15:0] tbl_radius [SLOTS] = '{default: '0};
    logic [15:0] tbl_decay  [SLOTS] = '{default: '0};

    slot_req_t    pending_reqs[$];
    slot_report_t slot_reports_due[$];
    slot_req_t    in_flight_req;
    slot_report_t due_report;

    int error_count     = 0;
    int gen_count       = 0;
    int reqs_taken      = 0;
    int results_checked = 0;
    int stuck_cycles    = 0;
    int alloc_cnt       = 0;
    int tick_cnt        = 0;
    int list_cnt        = 0;
    int full_lists      = 0;
    int reuse_hits      = 0;
    int fallback_picks  = 0;
    int expiry_drops    = 0;
    int decay_zeroed    = 0;
    int partial_decays  = 0;

    logic [1:0] idle_mode;
    int         src_idle_pct;
    int         sink_stall_pct;

    keyed_expiring_slot_table_core #(
        .SLOTS (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // rotate through the idling phases as input transfers go by
    assign idle_mode      = 2'((reqs_taken / 40) % 4);
    assign src_idle_pct   = (idle_mode == IDLE_SRC)  ? 75 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    assign sink_stall_pct = (idle_mode == IDLE_SINK) ? 75 : (idle_mode == IDLE_BOTH) ? 8 : 0;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_req(input kind_t kind, input logic [15:0] key,
                            input logic [31:0] now_ms, input logic [31:0] die_ms,
                            input logic [15:0] start_radius,
                            input logic [15:0] decay_rate, input logic [9:0] frame_ms);
        slot_req_t r;
        r.kind         = kind;
        r.key          = key;
        r.now_ms       = now_ms;
        r.die_ms       = die_ms;
        r.start_radius = start_radius;
        r.decay_rate   = decay_rate;
        r.frame_ms     = frame_ms;
        pending_reqs.push_back(r);
        if (kind != KIND_NONE)
            gen_count++;
    endtask

    // apply one accepted item to the shadow table and queue the reports it causes
    task automatic update_slot_table(input slot_req_t r);
        int           pick;
        bit           found;
        int           live;
        int           n;
        logic [31:0]  drop;
        slot_report_t res;
        case (r.kind)
            KIND_ALLOC:
            begin
                alloc_cnt++;
                pick  = 0;
                found = 1'b0;
                // reuse the first slot owned by a nonzero key
                if (r.key != 16'd0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && tbl_key[i] == r.key)
                        begin
                            pick  = i;
                            found = 1'b1;
                            reuse_hits++;
                        end
                    end
                end
                // else the first expired slot
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && tbl_expiry[i] < r.now_ms)
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                    fallback_picks++;
                tbl_key[pick]    = r.key;
                tbl_expiry[pick] = r.die_ms;
                tbl_radius[pick] = r.start_radius;
                tbl_decay[pick]  = r.decay_rate;
                res = '{5'(pick), r.key, r.start_radius, 1'b1, 1'b1};
                slot_reports_due.push_back(res);
            end
            KIND_TICK:
            begin
                tick_cnt++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_radius[i] != 16'd0)
                    begin
                        if (tbl_expiry[i] < r.now_ms)
                        begin
                            tbl_radius[i] = '0;
                            expiry_drops++;
                        end
                        else
                        begin
                            drop = (32'(r.frame_ms) * 32'(tbl_decay[i])) / 32'd1000;
                            if (drop >= 32'(tbl_radius[i]))
                            begin
                                tbl_radius[i] = '0;
                                decay_zeroed++;
                            end
                            else
                            begin
                                tbl_radius[i] = tbl_radius[i] - drop[15:0];
                                if (drop != 32'd0)
                                    partial_decays++;
                            end
                        end
                    end
                end
                res = '{5'd0, 16'd0, 16'd0, 1'b0, 1'b1};
                slot_reports_due.push_back(res);
            end
            KIND_LIST:
            begin
                list_cnt++;
                live = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_radius[i] != 16'd0)
                        live++;
                if (live > MAX_RESULTS)
                    live = MAX_RESULTS;
                if (live == MAX_RESULTS)
                    full_lists++;
                if (live == 0)
                begin
                    res = '{5'd0, 16'd0, 16'd0, 1'b0, 1'b1};
                    slot_reports_due.push_back(res);
                end
                n = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_radius[i] != 16'd0 && n < live)
                    begin
                        n++;
                        res = '{5'(i), tbl_key[i], tbl_radius[i], 1'b1, n == live};
                        slot_reports_due.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // input driver: predict on each transfer, then present the next item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                update_slot_table(in_flight_req);
                reqs_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    in_flight_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'({6'd0, in_flight_req.frame_ms,
                                             in_flight_req.decay_rate,
                                             in_flight_req.start_radius,
                                             in_flight_req.die_ms,
                                             in_flight_req.now_ms, in_flight_req.key});
                    s_tuser  <= in_flight_req.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // output monitor: compare each transfer with the oldest report due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (slot_reports_due.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing due: tdata=%h user=%b last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                due_report = slot_reports_due.pop_front();
                if (m_tdata[4:0] !== due_report.slot)
                    report_mismatch($sformatf("slot: got %0d want %0d",
                                              m_tdata[4:0], due_report.slot));
                if (m_tdata[20:5] !== due_report.slot_key)
                    report_mismatch($sformatf("slot_key: got %h want %h",
                                              m_tdata[20:5], due_report.slot_key));
                if (m_tdata[36:21] !== due_report.radius_out)
                    report_mismatch($sformatf("radius_out: got %h want %h",
                                              m_tdata[36:21], due_report.radius_out));
                if (m_tuser[0] !== due_report.entry_valid)
                    report_mismatch($sformatf("entry_valid: got %b want %b",
                                              m_tuser[0], due_report.entry_valid));
                if (m_tlast !== due_report.last)
                    report_mismatch($sformatf("last: got %b want %b",
                                              m_tlast, due_report.last));
            end
        end
    end

    // watchdog: count cycles with work outstanding and no transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (pending_reqs.size() == 0 && !s_tvalid && slot_reports_due.size() == 0))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d reports due",
                         stuck_cycles, slot_reports_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [31:0] t;
        logic [31:0] die;
        logic [15:0] key_pool [6];
        logic [15:0] kk;
        logic [15:0] rad;
        logic [15:0] dec;
        int          base_count;
        int          sel;
        int          pick;

        // empty table: list and tick acknowledge, unused kind
        push_req(KIND_LIST, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 10'h0);
        push_req(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 10'h3FF);
        push_req(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 10'h3FF);
        // nothing expired before time zero: fall back to slot 0
        push_req(KIND_ALLOC, 16'h0000, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 10'h0);
        // first expired slot, then reuse by key
        push_req(KIND_ALLOC, 16'hFFFF, 32'h1, 32'h0, 16'h0001, 16'hFFFF, 10'h0);
        push_req(KIND_ALLOC, 16'hFFFF, 32'h0, 32'h8000_0000, 16'h1234, 16'h0100, 10'h0);
        push_req(KIND_ALLOC, 16'h00A5, 32'hFFFF_FFFF, 32'd100, 16'h0800, 16'd1000, 10'h0);
        push_req(KIND_ALLOC, 16'h5A00, 32'd5, 32'd500, 16'h0400, 16'd4000, 10'h0);
        push_req(KIND_ALLOC, 16'h0007, 32'd5, 32'd900, 16'h0000, 16'h0040, 10'h0);
        push_req(KIND_ALLOC, 16'h0100, 32'd5, 32'hFFFF_FFFF, 16'h8000, 16'd1000, 10'h0);
        push_req(KIND_ALLOC, 16'h0200, 32'd5, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 10'h0);
        push_req(KIND_LIST, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 10'h0);
        // expiry drop and partial shrink in one walk, saturation to zero in the next
        push_req(KIND_TICK, 16'h0000, 32'd200, 32'h0, 16'h0, 16'h0, 10'd10);
        push_req(KIND_LIST, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 10'h0);
        push_req(KIND_TICK, 16'h0000, 32'd200, 32'h0, 16'h0, 16'h0, 10'h3FF);
        push_req(KIND_TICK, 16'h0000, 32'd0, 32'h0, 16'h0, 16'h0, 10'h0);
        push_req(KIND_LIST, 16'h0000, 32'h0, 32'h0, 16'h0, 16'h0, 10'h0);

        // random episodes
        base_count = gen_count;
        t = $urandom();
        while (gen_count - base_count < RAND_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 7)
            begin
                // allocate one live entry per slot, list all, then decay them
                for (int k = 0; k < SLOTS; k++)
                    push_req(KIND_ALLOC, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom()),
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'($urandom_range(1, 65535)),
                             16'($urandom()), 10'($urandom()));
                push_req(KIND_LIST, 16'($urandom()), $urandom(), $urandom(),
                         16'($urandom()), 16'($urandom()), 10'($urandom()));
                push_req(KIND_TICK, 16'($urandom()), 32'($urandom_range(0, 1000)), $urandom(),
                         16'($urandom()), 16'($urandom()), 10'($urandom()));
                push_req(KIND_LIST, 16'($urandom()), $urandom(), $urandom(),
                         16'($urandom()), 16'($urandom()), 10'($urandom()));
            end
            else if (sel < 15)
            begin
                // noise: any kind, any fields
                repeat ($urandom_range(1, 4))
                    push_req(kind_t'(2'($urandom_range(0, 3))), 16'($urandom()), $urandom(),
                             $urandom(), 16'($urandom()), 16'($urandom()), 10'($urandom()));
            end
            else
            begin
                // ordinary frame traffic around a moving time base
                if ($urandom_range(0, 6) == 0)
                    t = $urandom();
                else if ($urandom_range(0, 19) == 0)
                    t = 32'hFFFF_F000 + 32'($urandom_range(0, 4095));
                foreach (key_pool[j])
                    key_pool[j] = 16'($urandom_range(1, 65535));
                repeat ($urandom_range(3, 10))
                begin
                    t = t + 32'($urandom_range(0, 2000));
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                    begin
                        kk  = ($urandom_range(0, 9) == 0) ? 16'd0 :
                              ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                              key_pool[$urandom_range(0, 5)];
                        die = ($urandom_range(0, 19) == 0) ? $urandom() :
                              t + 32'($urandom_range(0, 5000));
                        rad = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom());
                        dec = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                              16'($urandom_range(0, 4000));
                        push_req(KIND_ALLOC, kk, t, die, rad, dec, 10'($urandom()));
                    end
                    else if (pick < 82)
                        push_req(KIND_TICK, 16'($urandom()), t, $urandom(), 16'($urandom()),
                                 16'($urandom()), 10'($urandom()));
                    else if (pick < 97)
                        push_req(KIND_LIST, 16'($urandom()), $urandom(), $urandom(),
                                 16'($urandom()), 16'($urandom()), 10'($urandom()));
                    else
                        push_req(KIND_NONE, 16'($urandom()), $urandom(), $urandom(),
                                 16'($urandom()), 16'($urandom()), 10'($urandom()));
                end
            end
        end

        // hold reset, then release
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all items sent and every report received
        @(posedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || slot_reports_due.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("run: %0d items in (%0d allocate, %0d tick, %0d list), %0d results checked",
                 reqs_taken, alloc_cnt, tick_cnt, list_cnt, results_checked);
        $display("run: %0d key reuses, %0d slot-0 fallbacks, %0d full lists, %0d expired, %0d %s",
                 reuse_hits, fallback_picks, full_lists, expiry_drops,
                 decay_zeroed + partial_decays, "decayed");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[keyed_expiring_slot_table_core.f]
+incdir+rtl
rtl/kest_pkg.sv
rtl/kest_cell.sv
rtl/kest_head.sv
rtl/kest_ctrl.sv
rtl/keyed_expiring_slot_table_core.sv
verif/testbench.sv
